// ===== sv/sls_pkg.sv =====
// Package for the sorted list store: constants, payload types and address helpers.
`default_nettype none

package sls_pkg;

   localparam int DEPTH  = 256;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;

   typedef logic [2:0] func_type;

   localparam func_type FUNC_PUSH   = 3'd0;
   localparam func_type FUNC_POP    = 3'd1;
   localparam func_type FUNC_INSERT = 3'd2;
   localparam func_type FUNC_ERASE  = 3'd3;
   localparam func_type FUNC_GET    = 3'd4;
   localparam func_type FUNC_CLEAR  = 3'd5;

   localparam logic signed [DATA_W-1:0] NEG_ONE = '1;

   typedef struct packed {
      func_type                  func;
      logic signed [DATA_W-1:0]  item_value;
      logic [7:0]                position;
   } req_type;

   typedef struct packed {
      logic                      ok;
      logic signed [DATA_W-1:0]  read_value;
      logic [8:0]                entry_count;
   } rsp_type;

   // Physical address of the entry that lies rel places after the head.
   function automatic logic [ADDR_W-1:0] wrap_addr(input logic [ADDR_W-1:0] base,
                                                   input logic [CNT_W-1:0] rel);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(base) + (CNT_W+1)'(rel);
      if (sum >= (CNT_W+1)'(DEPTH)) begin
         sum = sum - (CNT_W+1)'(DEPTH);
      end
      return sum[ADDR_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== sv/sls_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module sls_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== sv/sorted_list_store_core.sv =====
// Sorted list store: circular list in one RAM with a sequencer for all six operations.
// Push, clear and refused operations go straight to the done state, which loads the result.
// Pop and get pass through a wait state that takes the registered RAM read before done.
// Erase scans the list; insert scans it, then writes the tail, or fills an empty list at once.
// One item is in work at a time; the next is taken once the result is in the output register.
// Reset empties the list and sets the head to zero; the RAM contents are not cleared.
`default_nettype none

module sorted_list_store_core
   import sls_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_TAIL,
      ST_WAIT,
      ST_DONE
   } state_type;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [ADDR_W-1:0]        head_ff, head_in;
   func_type                 op_ff, op_in;
   logic signed [DATA_W-1:0] val_ff, val_in;
   logic [CNT_W-1:0]         rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]         proc_idx_ff, proc_idx_in;
   logic [CNT_W-1:0]         wr_idx_ff, wr_idx_in;
   logic                     found_ff, found_in;
   logic [DATA_W-1:0]        carry_ff, carry_in;
   logic                     res_ok_ff, res_ok_in;
   logic signed [DATA_W-1:0] res_rd_ff, res_rd_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   logic                     mem_we;
   logic [ADDR_W-1:0]        mem_wa;
   logic [DATA_W-1:0]        mem_wd;
   logic [ADDR_W-1:0]        mem_ra;
   logic [DATA_W-1:0]        mem_rd;
   logic                     accept;
   logic                     last;
   logic                     hit;

   sls_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_addr (mem_ra),
      .rd_data (mem_rd)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign last      = (proc_idx_ff == count_ff - CNT_W'(1));
   assign hit       = (mem_rd == val_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      head_in      = head_ff;
      op_in        = op_ff;
      val_in       = val_ff;
      rd_idx_in    = rd_idx_ff;
      proc_idx_in  = proc_idx_ff;
      wr_idx_in    = wr_idx_ff;
      found_in     = found_ff;
      carry_in     = carry_ff;
      res_ok_in    = res_ok_ff;
      res_rd_in    = res_rd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_wa       = wrap_addr(head_ff, count_ff);
      mem_wd       = val_ff;
      mem_ra       = wrap_addr(head_ff, rd_idx_ff);

      case (state_ff)
         ST_IDLE: begin
            mem_ra = head_ff;
            if (accept) begin
               op_in       = req_data.func;
               val_in      = req_data.item_value;
               res_ok_in   = 1'b0;
               res_rd_in   = NEG_ONE;
               rd_idx_in   = CNT_W'(1);
               proc_idx_in = '0;
               wr_idx_in   = '0;
               found_in    = 1'b0;
               state_in    = ST_DONE;
               case (req_data.func)
                  FUNC_PUSH: begin
                     if (!req_data.item_value[DATA_W-1] && count_ff < CNT_W'(DEPTH)) begin
                        mem_we    = 1'b1;
                        mem_wa    = wrap_addr(head_ff, count_ff);
                        mem_wd    = req_data.item_value;
                        count_in  = count_ff + CNT_W'(1);
                        res_ok_in = 1'b1;
                     end
                  end
                  FUNC_POP: begin
                     if (count_ff != '0) begin
                        state_in = ST_WAIT;
                     end
                  end
                  FUNC_INSERT: begin
                     if (count_ff == '0) begin
                        mem_we    = 1'b1;
                        mem_wa    = head_ff;
                        mem_wd    = req_data.item_value;
                        count_in  = CNT_W'(1);
                        res_ok_in = 1'b1;
                     end else if (count_ff < CNT_W'(DEPTH)) begin
                        state_in = ST_SCAN;
                     end
                  end
                  FUNC_ERASE: begin
                     if (count_ff != '0) begin
                        state_in = ST_SCAN;
                     end
                  end
                  FUNC_GET: begin
                     mem_ra = wrap_addr(head_ff, CNT_W'(req_data.position));
                     if (CNT_W'(req_data.position) < count_ff) begin
                        state_in = ST_WAIT;
                     end
                  end
                  FUNC_CLEAR: begin
                     count_in  = '0;
                     res_ok_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            rd_idx_in   = rd_idx_ff + CNT_W'(1);
            proc_idx_in = proc_idx_ff + CNT_W'(1);
            if (op_ff == FUNC_INSERT) begin
               if (found_ff || $signed(mem_rd) < val_ff) begin
                  mem_we   = 1'b1;
                  mem_wa   = wrap_addr(head_ff, proc_idx_ff);
                  mem_wd   = found_ff ? carry_ff : val_ff;
                  carry_in = mem_rd;
                  found_in = 1'b1;
               end
               if (last) begin
                  state_in = ST_TAIL;
               end
            end else begin
               if (hit) begin
                  found_in = 1'b1;
               end else begin
                  mem_we    = 1'b1;
                  mem_wa    = wrap_addr(head_ff, wr_idx_ff);
                  mem_wd    = mem_rd;
                  wr_idx_in = wr_idx_ff + CNT_W'(1);
               end
               if (last) begin
                  count_in  = wr_idx_in;
                  res_ok_in = found_in;
                  state_in  = ST_DONE;
               end
            end
         end
         ST_TAIL: begin
            mem_we    = 1'b1;
            mem_wa    = wrap_addr(head_ff, count_ff);
            mem_wd    = found_ff ? carry_ff : val_ff;
            count_in  = count_ff + CNT_W'(1);
            res_ok_in = 1'b1;
            state_in  = ST_DONE;
         end
         ST_WAIT: begin
            res_rd_in = $signed(mem_rd);
            res_ok_in = 1'b1;
            if (op_ff == FUNC_POP) begin
               head_in  = wrap_addr(head_ff, CNT_W'(1));
               count_in = count_ff - CNT_W'(1);
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.ok          = res_ok_ff;
               rsp_data_in.read_value  = res_rd_ff;
               rsp_data_in.entry_count = 9'(count_ff);
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      val_ff      <= val_in;
      rd_idx_ff   <= rd_idx_in;
      proc_idx_ff <= proc_idx_in;
      wr_idx_ff   <= wr_idx_in;
      found_ff    <= found_in;
      carry_ff    <= carry_in;
      res_ok_ff   <= res_ok_in;
      res_rd_ff   <= res_rd_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count exceeds the store depth");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("accepted item did not start work");

   a_scan_within_list: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> proc_idx_ff < count_ff)
      else $error("scan ran past the end of the list");

   a_refused_reads_neg_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.ok |-> rsp_data_ff.read_value == NEG_ONE)
      else $error("refused item returned a value");

   a_result_waits_for_done: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff ##1 rsp_valid_ff |-> $past(state_ff) == ST_DONE)
      else $error("result loaded outside of the done state");

endmodule

`default_nettype wire
